/* sv/ftbp_pkg.sv */
package ftbp_pkg;

    localparam int FLOW_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);
    localparam int MIN_BURST  = 1500;

    localparam int FLOW_W = 12;
    localparam int LEN_W  = 16;
    localparam int TIME_W = 64;
    localparam int RATE_W = 40;
    localparam int TOK_W  = 37;
    localparam int CNT_W  = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Refill arithmetic: 64 x 40 bit product, quotient by one second in ns.
    localparam int           PROD_W     = TIME_W + RATE_W;
    localparam int           ACC_W      = 128;
    localparam int           QUO_W      = 38;
    localparam longint       NS_PER_SEC = 64'd1000000000;
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(NS_PER_SEC) << QUO_W;
    localparam int           BURST_DIV  = 10;

    // One second in ns is 2^9 times an odd factor. Below SAT_LIMIT the product
    // shifted right by 9 fits in PRE_W bits, and a multiply by the rounded-up
    // reciprocal of the odd factor gives the exact floor.
    localparam int                NS_SHIFT     = 9;
    localparam int                NS_ODD       = 1953125;
    localparam int                PRE_W        = 59;
    localparam int                RECIP_NS_SH  = 80;
    localparam logic [59:0]       RECIP_NS     =
        60'(((81'd1 << RECIP_NS_SH) + 81'(NS_ODD - 1)) / 81'(NS_ODD));

    // rate / 10 is (rate >> 1) / 5, again by a rounded-up reciprocal.
    localparam int                RECIP_5_SH   = 42;
    localparam logic [RATE_W-1:0] RECIP_5      =
        RATE_W'(((64'd1 << RECIP_5_SH) + 64'(BURST_DIV / 2 - 1)) / 64'(BURST_DIV / 2));

    // Sequence points of the refill unit, which runs in three stages.
    localparam int              RC_W        = 5;
    localparam logic [2:0]      RC_MUL_LAST = 3'd3;
    localparam logic [2:0]      RC_ACC_LAST = 3'd4;
    localparam logic [2:0]      RC_EXTRACT  = 3'd5;
    localparam logic [1:0]      RS_BURST    = 2'd0;
    localparam logic [1:0]      RS_PRODUCT  = 2'd1;
    localparam logic [RC_W-1:0] RC_LAST     = 5'd21;

    typedef enum logic [1:0] {
        REQ_PACKET      = 2'd0,
        REQ_SET_RATE    = 2'd1,
        REQ_REMOVE_RATE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_MARK = 2'd1,
        VERDICT_DROP = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_UPDATE
    } t_bstate;

    typedef struct packed {
        t_req               kind;
        logic [SLOT_W-1:0]  slot;
        logic [FLOW_W-1:0]  flow;
        logic [LEN_W-1:0]   len;
        logic [TIME_W-1:0]  now;
        logic               ecn;
        logic [RATE_W-1:0]  rate;
    } t_job;

    typedef struct packed {
        logic               rate_valid;
        logic [RATE_W-1:0]  rate;
        logic               bkt_valid;
        logic [TOK_W-1:0]   tokens;
        logic [TIME_W-1:0]  last;
        logic [CNT_W-1:0]   byte_cnt;
        logic [CNT_W-1:0]   rx_pkts;
        logic [CNT_W-1:0]   drops;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  elapsed;
        logic [RATE_W-1:0]  rate;
    } t_refill_req;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [QUO_W-1:0]   add;
        logic [TOK_W-1:0]   burst;
    } t_refill_res;

endpackage

/* sv/ftbp_req_if.sv */
interface ftbp_req_if import ftbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [FLOW_W-1:0] flow;
    logic [LEN_W-1:0]  pkt_length;
    logic [TIME_W-1:0] now_ns;
    logic              ecn_capable;
    logic [RATE_W-1:0] rate_value;

    modport source (output valid, req_type, flow, pkt_length, now_ns, ecn_capable,
                    rate_value, input ready);
    modport sink (input valid, req_type, flow, pkt_length, now_ns, ecn_capable,
                  rate_value, output ready);
endinterface

/* sv/ftbp_res_if.sv */
interface ftbp_res_if import ftbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        verdict;
    logic [FLOW_W-1:0] out_flow;
    logic [TOK_W-1:0]  tokens_left;
    logic [CNT_W-1:0]  rx_bytes_total;
    logic [CNT_W-1:0]  rx_packets_total;
    logic [CNT_W-1:0]  drops_total;

    modport source (output valid, verdict, out_flow, tokens_left, rx_bytes_total,
                    rx_packets_total, drops_total, input ready);
    modport sink (input valid, verdict, out_flow, tokens_left, rx_bytes_total,
                  rx_packets_total, drops_total, output ready);
endinterface

/* sv/ftbp_ram.sv */
module ftbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/ftbp_front.sv */
module ftbp_front import ftbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_hold,
    ftbp_req_if.sink   i_req,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_job       o_job
);
    logic r_valid;
    t_job r_job;
    logic accept;
    logic known;

    // Items with an unknown request type are taken and discarded here.
    assign known = (i_req.req_type == REQ_PACKET) || (i_req.req_type == REQ_SET_RATE) ||
                   (i_req.req_type == REQ_REMOVE_RATE);
    assign o_push      = r_valid && i_q_ready;
    assign i_req.ready = !i_hold && (!r_valid || i_q_ready);
    assign accept      = i_req.valid && i_req.ready;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= known;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.kind <= t_req'(i_req.req_type);
            r_job.slot <= SLOT_W'(i_req.flow);
            r_job.flow <= i_req.flow;
            r_job.len  <= i_req.pkt_length;
            r_job.now  <= i_req.now_ns;
            r_job.ecn  <= i_req.ecn_capable;
            r_job.rate <= i_req.rate_value;
        end
    end
endmodule

/* sv/ftbp_queue.sv */
module ftbp_queue import ftbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);
    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

/* sv/ftbp_refill.sv */
module ftbp_refill import ftbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_refill_req i_req,
    output t_refill_res o_res
);
    logic               r_busy;
    logic               r_done;
    logic [RC_W-1:0]    r_cnt;
    logic [TIME_W-1:0]  r_a;
    logic [RATE_W-1:0]  r_b;
    logic [63:0]        r_x;
    logic [63:0]        r_y;
    logic [63:0]        r_pp;
    logic [1:0]         r_pp_sel;
    logic [ACC_W-1:0]   r_acc;
    logic [QUO_W-1:0]   r_quo;
    logic               r_sat;
    logic [TOK_W-1:0]   r_burst;

    logic [2:0]         step;
    logic [1:0]         stage;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [ACC_W-1:0]   pp_al;
    logic [TOK_W-1:0]   burst_raw;

    // Each stage is one 64 x 64 multiply on a single 32 x 32 multiplier: four
    // partial products, each summed the cycle after it is formed. The stages
    // are burst (rate / 10), refill product and quotient by one second.
    assign step      = r_cnt[2:0];
    assign stage     = r_cnt[4:3];
    assign burst_raw = r_acc[RECIP_5_SH +: TOK_W];

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                op_a = r_x[31:0];
                op_b = r_y[31:0];
            end
            2'd1: begin
                op_a = r_x[31:0];
                op_b = r_y[63:32];
            end
            2'd2: begin
                op_a = r_x[63:32];
                op_b = r_y[31:0];
            end
            default: begin
                op_a = r_x[63:32];
                op_b = r_y[63:32];
            end
        endcase
        case (r_pp_sel)
            2'd0:    pp_al = ACC_W'(r_pp);
            2'd3:    pp_al = ACC_W'(r_pp) << 64;
            default: pp_al = ACC_W'(r_pp) << 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == RC_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.elapsed;
            r_b   <= i_req.rate;
            r_x   <= 64'(i_req.rate[RATE_W-1:1]);
            r_y   <= 64'(RECIP_5);
            r_acc <= '0;
        end else if (r_busy) begin
            if (step <= RC_MUL_LAST) begin
                r_pp     <= op_a * op_b;
                r_pp_sel <= r_cnt[1:0];
            end
            if (step != '0 && step <= RC_ACC_LAST) begin
                r_acc <= r_acc + pp_al;
            end
            if (step == RC_EXTRACT) begin
                r_acc <= '0;
                case (stage)
                    RS_BURST: begin
                        r_burst <= (burst_raw < TOK_W'(MIN_BURST)) ? TOK_W'(MIN_BURST)
                                                                   : burst_raw;
                        r_x     <= r_a;
                        r_y     <= 64'(r_b);
                    end
                    RS_PRODUCT: begin
                        // Past the limit the quotient exceeds any burst.
                        r_sat <= (r_acc[PROD_W-1:0] >= SAT_LIMIT);
                        r_x   <= 64'(r_acc[PRE_W+NS_SHIFT-1:NS_SHIFT]);
                        r_y   <= 64'(RECIP_NS);
                    end
                    default: begin
                        r_quo <= r_acc[RECIP_NS_SH +: QUO_W];
                    end
                endcase
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.sat   = r_sat;
    assign o_res.add   = r_quo;
    assign o_res.burst = r_burst;
endmodule

/* sv/ftbp_back.sv */
module ftbp_back import ftbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [RATE_W-1:0] i_default_rate,
    input  logic              i_q_valid,
    input  t_job              i_q_job,
    output logic              o_q_pop,
    output logic              o_clearing,
    ftbp_res_if.source        o_res
);
    t_bstate           r_state;
    t_bstate           n_state;
    logic [SLOT_W-1:0] r_clr_addr;
    t_job              r_job;
    logic              r_out_valid;
    t_verdict          r_verdict;
    logic [FLOW_W-1:0] r_out_flow;
    logic [TOK_W-1:0]  r_tokens_left;
    logic [CNT_W-1:0]  r_rxb;
    logic [CNT_W-1:0]  r_rxp;
    logic [CNT_W-1:0]  r_drops;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    t_row              wrow;
    logic [SLOT_W-1:0] raddr;
    logic [ROW_W-1:0]  rdata;
    t_row              row;
    t_refill_req       rf_req;
    t_refill_res       rf_res;

    logic [RATE_W-1:0] rate;
    logic              out_free;
    logic              load_out;
    logic [TOK_W+1:0]  sum;
    logic [TOK_W-1:0]  capped;
    t_verdict          verdict;
    logic [TOK_W-1:0]  tokens;
    t_row              upd;

    ftbp_ram #(.WIDTH(ROW_W), .DEPTH(FLOW_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ftbp_refill u_refill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_res   (rf_res)
    );

    assign row      = t_row'(rdata);
    assign rate     = row.rate_valid ? row.rate : i_default_rate;
    assign out_free = !r_out_valid || o_res.ready;
    assign raddr    = (r_state == ST_IDLE) ? i_q_job.slot : r_job.slot;

    // Packet update: refill, cap, debit and counters.
    always_comb begin
        sum = (TOK_W + 2)'(row.tokens) + (TOK_W + 2)'(rf_res.add);
        if (rf_res.sat || (rf_res.add >= QUO_W'(rf_res.burst)) ||
            (sum > (TOK_W + 2)'(rf_res.burst))) begin
            capped = rf_res.burst;
        end else begin
            capped = sum[TOK_W-1:0];
        end
        upd     = row;
        verdict = VERDICT_PASS;
        tokens  = '0;
        if (rate != '0) begin
            upd.last      = r_job.now;
            upd.bkt_valid = 1'b1;
            if (row.bkt_valid) begin
                if (capped >= TOK_W'(r_job.len)) begin
                    tokens = capped - TOK_W'(r_job.len);
                end else begin
                    tokens  = capped;
                    verdict = r_job.ecn ? VERDICT_MARK : VERDICT_DROP;
                end
            end else if (rf_res.burst >= TOK_W'(r_job.len)) begin
                tokens = rf_res.burst - TOK_W'(r_job.len);
            end
            upd.tokens = tokens;
        end
        if (verdict == VERDICT_DROP) begin
            upd.drops = row.drops + 1'b1;
        end else begin
            upd.byte_cnt = row.byte_cnt + CNT_W'(r_job.len);
            upd.rx_pkts  = row.rx_pkts + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        we             = 1'b0;
        waddr          = r_job.slot;
        wrow           = row;
        o_q_pop        = 1'b0;
        rf_req.start   = 1'b0;
        rf_req.elapsed = r_job.now - row.last;
        rf_req.rate    = rate;
        load_out       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wrow  = '0;
                if (r_clr_addr == SLOT_W'(FLOW_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                unique case (r_job.kind)
                    REQ_SET_RATE: begin
                        we              = 1'b1;
                        wrow.rate_valid = 1'b1;
                        wrow.rate       = r_job.rate;
                        n_state         = ST_IDLE;
                    end
                    REQ_REMOVE_RATE: begin
                        we              = 1'b1;
                        wrow.rate_valid = 1'b0;
                        wrow.rate       = '0;
                        n_state         = ST_IDLE;
                    end
                    default: begin
                        if (rate == '0) begin
                            n_state = ST_UPDATE;
                        end else begin
                            rf_req.start = 1'b1;
                            n_state      = ST_CALC;
                        end
                    end
                endcase
            end
            ST_CALC: begin
                if (rf_res.done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    we       = 1'b1;
                    wrow     = upd;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (load_out) begin
            r_verdict     <= verdict;
            r_out_flow    <= r_job.flow;
            r_tokens_left <= tokens;
            r_rxb         <= upd.byte_cnt;
            r_rxp         <= upd.rx_pkts;
            r_drops       <= upd.drops;
        end
    end

    assign o_clearing             = (r_state == ST_CLEAR);
    assign o_res.valid            = r_out_valid;
    assign o_res.verdict          = r_verdict;
    assign o_res.out_flow         = r_out_flow;
    assign o_res.tokens_left      = r_tokens_left;
    assign o_res.rx_bytes_total   = r_rxb;
    assign o_res.rx_packets_total = r_rxp;
    assign o_res.drops_total      = r_drops;
endmodule

/* sv/per_flow_token_bucket_policer.sv */
// Per-flow ingress token-bucket policer with congestion marking.
// Items enter on i_req: a packet, a per-flow rate set, or a per-flow rate
// removal. Only packet items produce an item on o_res, carrying the verdict
// (pass, pass with CE mark, drop), the bucket level and the flow's counters.
// The default rate for flows without their own rate is written over APB at
// byte address 0. The user writes only while the block is idle; not enforced.
// A front stage takes and classifies items and drops unknown request types,
// a two-entry queue decouples it from the back stage, which does the
// per-flow read-modify-write on one memory row.
// In the back stage a rate item passes the read state; a packet on an
// unlimited flow passes read and update, and a rate-limited packet waits
// in between on the refill unit: three multiplies of four 32x32 partial
// products each on one multiplier (burst as half the rate by a reciprocal
// of five, the refill product, and its quotient by one second through a
// reciprocal). Items pass the front register and the queue on their way
// in; the back stage takes one item at a time, the next only when done.
// After reset the block sweeps all 4096 flow rows to zero, one row per
// cycle, and holds i_req.ready low until the sweep is done.
// When the receiver stalls, one result waits in the output register while
// the back stage starts the next item; it stalls only when a second result
// is ready to be written.
module per_flow_token_bucket_policer import ftbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ftbp_req_if.sink    i_req,
    ftbp_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [RATE_W-1:0] r_default_rate;
    logic              clearing;
    logic              push;
    t_job              front_job;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    t_job              q_job;

    // Register 0 is decoded on the upper address bit alone.
    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? 64'(r_default_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_rate <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[3] == 1'b0)) begin
            r_default_rate <= pwdata[RATE_W-1:0];
        end
    end

    ftbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (clearing),
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (front_job)
    );

    ftbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ftbp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_default_rate (r_default_rate),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_q_pop        (q_pop),
        .o_clearing     (clearing),
        .o_res          (o_res)
    );
endmodule
